@@ rtl/tsme_pkg.sv @@
// Shared codes, widths and control/status types for the two-set membership engine.
`timescale 1ns / 1ps

package tsme_pkg;

    // Element and result field widths.
    localparam int DATA_W   = 32;
    localparam int CMD_W    = 3;
    localparam int COUNT_W  = 6;
    localparam int STATUS_W = 2;

    // Operation codes.
    localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CONTAINS  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SIZE      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_INTERSECT = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture the accepted input word
        logic scan_init;   // restart the search pipeline
        logic scan_step;   // advance the search by one entry
        logic shift_init;  // start closing the gap after the found entry
        logic shift_step;  // move one entry down
        logic op_finish;   // update count and load the result of a single-result command
        logic outer_init;  // restart the intersection walk over the first set
        logic fetch;       // read the next first-set entry
        logic cand_load;   // latch that entry as the search key
        logic pend_push;   // hold a match, releasing the previous one as a result
        logic x_finish;    // release the final intersection result
    } tsme_ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             hit;
        logic             scan_done;
        logic             shift_done;
        logic             outer_more;
        logic             pend_valid;
        logic             out_free;
    } tsme_status_t;

endpackage

@@ rtl/tsme_dp.sv @@
// Datapath of the two-set membership engine: set memories, counts, search and result register.
`timescale 1ns / 1ps

module tsme_dp #(
    parameter int SET_CAPACITY = 32
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  tsme_pkg::tsme_ctl_t                    ctl,
    output tsme_pkg::tsme_status_t                 sts,
    input  logic [tsme_pkg::CMD_W-1:0]             in_cmd,
    input  logic                                   in_set_select,
    input  logic signed [tsme_pkg::DATA_W-1:0]     in_value,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [tsme_pkg::DATA_W-1:0]     out_element,
    output logic                                   out_found,
    output logic [tsme_pkg::COUNT_W-1:0]           out_count,
    output logic [tsme_pkg::STATUS_W-1:0]          out_status,
    output logic                                   out_last
);

    localparam int AW  = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
    localparam int CW  = $clog2(SET_CAPACITY + 1);
    localparam int DW  = tsme_pkg::DATA_W;
    localparam int OCW = tsme_pkg::COUNT_W;
    localparam logic [CW-1:0] CAP = CW'(SET_CAPACITY);

    // Captured command.
    logic [tsme_pkg::CMD_W-1:0] cmd_reg;
    logic                       sel_reg;
    logic [DW-1:0]              value_reg;

    // Set storage and counts.
    logic [DW-1:0] mem1 [0:SET_CAPACITY-1];
    logic [DW-1:0] mem2 [0:SET_CAPACITY-1];
    logic [DW-1:0] rd1_reg;
    logic [DW-1:0] rd2_reg;
    logic [CW-1:0] cnt1_reg;
    logic [CW-1:0] cnt2_reg;

    // Search and shift pipeline.
    logic [CW-1:0] idx_reg;
    logic          rd_vld_reg;
    logic [AW-1:0] rd_idx_reg;
    logic          hit_reg;
    logic [AW-1:0] hit_idx_reg;

    // Intersection walk.
    logic [CW-1:0] jdx_reg;
    logic [DW-1:0] cand_reg;
    logic          pend_valid_reg;
    logic [DW-1:0] pend_elem_reg;

    // Result register.
    logic                              out_valid_reg;
    logic [DW-1:0]                     out_element_reg;
    logic                              out_found_reg;
    logic [OCW-1:0]                    out_count_reg;
    logic [tsme_pkg::STATUS_W-1:0]     out_status_reg;
    logic                              out_last_reg;

    logic                          xmode;
    logic                          use_second;
    logic [CW-1:0]                 n_sel;
    logic [DW-1:0]                 rd_sel;
    logic [DW-1:0]                 key;
    logic                          issue;
    logic                          match;
    logic                          idx_end;
    logic [AW-1:0]                 raddr;
    logic                          we;
    logic [AW-1:0]                 waddr;
    logic [DW-1:0]                 wdata;
    logic                          out_free;
    logic                          fin_found;
    logic [CW-1:0]                 fin_count;
    logic [tsme_pkg::STATUS_W-1:0] fin_status;
    logic                          cnt_we;
    logic                          load_out;
    logic [DW-1:0]                 elem_next;
    logic                          found_next;
    logic [CW-1:0]                 count_next;
    logic [tsme_pkg::STATUS_W-1:0] status_next;
    logic                          last_next;

    // The intersection always searches the second set with a first-set entry as key.
    assign xmode      = (cmd_reg == tsme_pkg::CMD_INTERSECT);
    assign use_second = xmode | sel_reg;
    assign n_sel      = use_second ? cnt2_reg : cnt1_reg;
    assign rd_sel     = use_second ? rd2_reg : rd1_reg;
    assign key        = xmode ? cand_reg : value_reg;

    // Read one entry per cycle while below the count; compare it in the following cycle.
    assign idx_end  = (idx_reg >= n_sel);
    assign issue    = (ctl.scan_step | ctl.shift_step) & ~idx_end;
    assign match    = rd_vld_reg & (rd_sel == key);
    assign raddr    = ctl.fetch ? jdx_reg[AW-1:0] : idx_reg[AW-1:0];
    assign out_free = ~out_valid_reg | out_ready;

    // Memory write: a shifted entry moves one place down, or an insert appends.
    always_comb begin
        we    = 1'b0;
        waddr = rd_idx_reg - AW'(1);
        wdata = rd_sel;
        if (ctl.shift_step && rd_vld_reg) begin
            we = 1'b1;
        end else if (ctl.op_finish && cmd_reg == tsme_pkg::CMD_INSERT && n_sel < CAP) begin
            we    = 1'b1;
            waddr = n_sel[AW-1:0];
            wdata = value_reg;
        end
    end

    // Fields and new count of a single-result command.
    always_comb begin
        fin_found  = hit_reg;
        fin_count  = n_sel;
        fin_status = tsme_pkg::ST_OK;
        cnt_we     = 1'b0;
        case (cmd_reg)
            tsme_pkg::CMD_INSERT: begin
                if (n_sel >= CAP) begin
                    fin_status = tsme_pkg::ST_FULL;
                end else begin
                    fin_count = n_sel + CW'(1);
                    cnt_we    = 1'b1;
                end
            end
            tsme_pkg::CMD_REMOVE: begin
                if (hit_reg) begin
                    fin_count = n_sel - CW'(1);
                    cnt_we    = 1'b1;
                end else begin
                    fin_status = tsme_pkg::ST_NOT_FOUND;
                end
            end
            tsme_pkg::CMD_CONTAINS: begin
                if (!hit_reg) begin
                    fin_status = tsme_pkg::ST_NOT_FOUND;
                end
            end
            default: begin
                fin_found = 1'b0;
            end
        endcase
    end

    // Result selection for the output register.
    always_comb begin
        load_out    = 1'b0;
        elem_next   = value_reg;
        found_next  = fin_found;
        count_next  = fin_count;
        status_next = fin_status;
        last_next   = 1'b1;
        if (ctl.op_finish) begin
            load_out = 1'b1;
        end else if (ctl.pend_push && pend_valid_reg) begin
            load_out    = 1'b1;
            elem_next   = pend_elem_reg;
            found_next  = 1'b1;
            count_next  = cnt1_reg;
            status_next = tsme_pkg::ST_OK;
            last_next   = 1'b0;
        end else if (ctl.x_finish) begin
            load_out   = 1'b1;
            count_next = cnt1_reg;
            if (pend_valid_reg) begin
                elem_next   = pend_elem_reg;
                found_next  = 1'b1;
                status_next = tsme_pkg::ST_OK;
            end else begin
                found_next  = 1'b0;
                status_next = tsme_pkg::ST_EMPTY;
            end
        end
    end

    // Set memories with registered read data.
    always_ff @(posedge aclk) begin
        if (we && !use_second) begin
            mem1[waddr] <= wdata;
        end
        if (we && use_second) begin
            mem2[waddr] <= wdata;
        end
        rd1_reg <= mem1[raddr];
        rd2_reg <= mem2[raddr];
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt1_reg       <= '0;
            cnt2_reg       <= '0;
            rd_vld_reg     <= 1'b0;
            hit_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            rd_vld_reg <= issue;
            if (ctl.scan_init) begin
                hit_reg <= 1'b0;
            end else if (ctl.scan_step && match) begin
                hit_reg <= 1'b1;
            end
            if (ctl.op_finish && cnt_we) begin
                if (use_second) begin
                    cnt2_reg <= fin_count;
                end else begin
                    cnt1_reg <= fin_count;
                end
            end
            if (ctl.outer_init) begin
                pend_valid_reg <= 1'b0;
            end else if (ctl.pend_push) begin
                pend_valid_reg <= 1'b1;
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            cmd_reg   <= in_cmd;
            sel_reg   <= in_set_select;
            value_reg <= in_value;
        end
        rd_idx_reg <= idx_reg[AW-1:0];
        if (ctl.scan_init) begin
            idx_reg <= '0;
        end else if (ctl.shift_init) begin
            idx_reg <= CW'(hit_idx_reg) + CW'(1);
        end else if (issue) begin
            idx_reg <= idx_reg + CW'(1);
        end
        if (ctl.scan_step && match && !hit_reg) begin
            hit_idx_reg <= rd_idx_reg;
        end
        if (ctl.outer_init) begin
            jdx_reg <= '0;
        end else if (ctl.cand_load) begin
            jdx_reg <= jdx_reg + CW'(1);
        end
        if (ctl.cand_load) begin
            cand_reg <= rd1_reg;
        end
        if (ctl.pend_push) begin
            pend_elem_reg <= cand_reg;
        end
        if (load_out) begin
            out_element_reg <= elem_next;
            out_found_reg   <= found_next;
            out_count_reg   <= OCW'(count_next);
            out_status_reg  <= status_next;
            out_last_reg    <= last_next;
        end
    end

    // Status back to the controller.
    always_comb begin
        sts.cmd        = cmd_reg;
        sts.hit        = hit_reg;
        sts.scan_done  = hit_reg | (idx_end & ~rd_vld_reg);
        sts.shift_done = idx_end & ~rd_vld_reg;
        sts.outer_more = (jdx_reg < cnt1_reg);
        sts.pend_valid = pend_valid_reg;
        sts.out_free   = out_free;
    end

    assign out_valid   = out_valid_reg;
    assign out_element = out_element_reg;
    assign out_found   = out_found_reg;
    assign out_count   = out_count_reg;
    assign out_status  = out_status_reg;
    assign out_last    = out_last_reg;

endmodule

@@ rtl/tsme_ctrl.sv @@
// Controller state machine of the two-set membership engine.
`timescale 1ns / 1ps

module tsme_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  tsme_pkg::tsme_status_t sts,
    output tsme_pkg::tsme_ctl_t    ctl
);

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_DISPATCH   = 4'd1;
    localparam logic [3:0] S_OP_SCAN    = 4'd2;
    localparam logic [3:0] S_SHIFT_INIT = 4'd3;
    localparam logic [3:0] S_SHIFT      = 4'd4;
    localparam logic [3:0] S_FINISH     = 4'd5;
    localparam logic [3:0] S_X_CHECK    = 4'd6;
    localparam logic [3:0] S_X_FETCH    = 4'd7;
    localparam logic [3:0] S_X_CAND     = 4'd8;
    localparam logic [3:0] S_X_SCAN     = 4'd9;
    localparam logic [3:0] S_X_HIT      = 4'd10;
    localparam logic [3:0] S_X_END      = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    // Next state and datapath commands.
    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    ctl.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                ctl.scan_init  = 1'b1;
                ctl.outer_init = 1'b1;
                case (sts.cmd)
                    tsme_pkg::CMD_INSERT, tsme_pkg::CMD_REMOVE, tsme_pkg::CMD_CONTAINS:
                        state_next = S_OP_SCAN;
                    tsme_pkg::CMD_SIZE:      state_next = S_FINISH;
                    tsme_pkg::CMD_INTERSECT: state_next = S_X_CHECK;
                    default:                 state_next = S_IDLE;
                endcase
            end
            S_OP_SCAN: begin
                if (sts.scan_done) begin
                    if (sts.cmd == tsme_pkg::CMD_REMOVE && sts.hit) begin
                        state_next = S_SHIFT_INIT;
                    end else begin
                        state_next = S_FINISH;
                    end
                end else begin
                    ctl.scan_step = 1'b1;
                end
            end
            S_SHIFT_INIT: begin
                ctl.shift_init = 1'b1;
                state_next     = S_SHIFT;
            end
            S_SHIFT: begin
                if (sts.shift_done) begin
                    state_next = S_FINISH;
                end else begin
                    ctl.shift_step = 1'b1;
                end
            end
            S_FINISH: begin
                if (sts.out_free) begin
                    ctl.op_finish = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_X_CHECK: begin
                state_next = sts.outer_more ? S_X_FETCH : S_X_END;
            end
            S_X_FETCH: begin
                ctl.fetch  = 1'b1;
                state_next = S_X_CAND;
            end
            S_X_CAND: begin
                ctl.cand_load = 1'b1;
                ctl.scan_init = 1'b1;
                state_next    = S_X_SCAN;
            end
            S_X_SCAN: begin
                if (sts.scan_done) begin
                    state_next = sts.hit ? S_X_HIT : S_X_CHECK;
                end else begin
                    ctl.scan_step = 1'b1;
                end
            end
            S_X_HIT: begin
                // A held match goes out only once the next one proves it is not the last.
                if (!sts.pend_valid || sts.out_free) begin
                    ctl.pend_push = 1'b1;
                    state_next    = S_X_CHECK;
                end
            end
            S_X_END: begin
                if (sts.out_free) begin
                    ctl.x_finish = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/two_set_membership_engine_core.sv @@
// Top level of the two-set membership engine: stream ports, controller and datapath.
//
// Usage: commands arrive on the s_ channel, one word each; results leave on the m_ channel.
// Insert, remove, contains and size each give exactly one result word with m_tlast set.
// Intersection gives one word per first-set entry found in the second set, in first-set
// order, with m_tlast on the final one, or a single word with status "empty intersection".
// Unused command codes are dropped without a result.
// s_tready is high only while the engine is idle; one command is worked on at a time.
// Insert and contains use a linear search of the chosen set, one memory read per cycle;
// remove searches the same way, then moves each later entry down one place, one entry
// per cycle; size needs no search. Intersection walks the first set and searches the
// second set for each entry, through the single read port of each set memory.
// The result sits in an output register; a stalled receiver holds the engine in its
// current step until the word is taken, and no word is lost or repeated.
// Reset (aresetn low, synchronous) empties both sets; no clearing pass is needed.
`timescale 1ns / 1ps

module two_set_membership_engine_core #(
    parameter int SET_CAPACITY = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [3:0]  s_tuser,   // [2:0] cmd, [3] set_select
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] element, [37:32] count, [39:38] zero
    output logic [2:0]  m_tuser,   // [0] found, [2:1] status
    output logic        m_tlast
);

    tsme_pkg::tsme_ctl_t    ctl;
    tsme_pkg::tsme_status_t sts;

    logic signed [tsme_pkg::DATA_W-1:0]  out_element;
    logic                                out_found;
    logic [tsme_pkg::COUNT_W-1:0]        out_count;
    logic [tsme_pkg::STATUS_W-1:0]       out_status;

    tsme_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    tsme_dp #(
        .SET_CAPACITY (SET_CAPACITY)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctl           (ctl),
        .sts           (sts),
        .in_cmd        (s_tuser[2:0]),
        .in_set_select (s_tuser[3]),
        .in_value      (s_tdata),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_element   (out_element),
        .out_found     (out_found),
        .out_count     (out_count),
        .out_status    (out_status),
        .out_last      (m_tlast)
    );

    // Pack the result word.
    assign m_tdata = {2'b00, out_count, out_element};
    assign m_tuser = {out_status, out_found};

endmodule
